// ----- design/rrss_pkg.sv -----
// rrss_pkg: shared widths, codes and reset values of the round-robin slice scheduler
// used by round_robin_slice_scheduler_core and tb_round_robin_slice_scheduler_core
// no dependencies
`timescale 1ns / 1ps

package rrss_pkg;

    // defaults of the top-level parameters
    localparam int MAX_JOBS_DEF  = 16;
    localparam int TIME_BITS_DEF = 16;

    // fixed field widths
    localparam int SLOT_W    = 4;
    localparam int BURST_W   = 16;
    localparam int QUANTUM_W = 16;
    localparam int JOBCNT_W  = 5;
    localparam int RUN_W     = 16;
    localparam int CLOCK_W   = 20;
    localparam int SUM_W     = 25;

    // stream widths
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 136;

    // saturation limits
    localparam logic [CLOCK_W-1:0] CLOCK_MAX = {CLOCK_W{1'b1}};
    localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};

    // item opcodes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_SLICE = 1'b1;

    // configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_QUANTUM   = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_JOB_COUNT = 1'b1;

    // configuration reset values
    localparam logic [QUANTUM_W-1:0] QUANTUM_RST = 16'd5;
    localparam logic [JOBCNT_W-1:0]  JOBCNT_RST  = 5'd4;

endpackage

// ----- design/rrss_job_mem.sv -----
// rrss_job_mem: remaining-time and burst-time tables, one synchronous memory each
// one write port and one read port per table, read data registered
// no dependencies
`timescale 1ns / 1ps

module rrss_job_mem #(
    parameter int MAX_JOBS  = 16,
    parameter int TIME_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rd_en,
    input  logic [$clog2(MAX_JOBS)-1:0] rd_addr,
    input  logic                        wr_en,
    input  logic [$clog2(MAX_JOBS)-1:0] wr_addr,
    input  logic [TIME_BITS-1:0]        wr_remaining,
    input  logic                        burst_wr_en,
    input  logic [TIME_BITS-1:0]        wr_burst,
    output logic [TIME_BITS-1:0]        rd_remaining,
    output logic [TIME_BITS-1:0]        rd_burst
);

    logic [TIME_BITS-1:0] remaining_mem [MAX_JOBS];
    logic [TIME_BITS-1:0] burst_mem     [MAX_JOBS];

    // remaining-time table
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            remaining_mem[wr_addr] <= wr_remaining;
        end
        if (rd_en)
        begin
            rd_remaining <= remaining_mem[rd_addr];
        end
    end

    // burst-time table, written by loads only
    always_ff @(posedge clk)
    begin
        if (burst_wr_en)
        begin
            burst_mem[wr_addr] <= wr_burst;
        end
        if (rd_en)
        begin
            rd_burst <= burst_mem[rd_addr];
        end
    end

endmodule

// ----- design/rrss_picker.sv -----
// rrss_picker: rotating first-live search over the live-slot flags
// finds the first live slot at or after the start slot, wrapping to slot 0
// no dependencies
`timescale 1ns / 1ps

module rrss_picker #(
    parameter int MAX_JOBS = 16
) (
    input  logic [MAX_JOBS-1:0]         live,
    input  logic [$clog2(MAX_JOBS):0]   jobs_used,
    input  logic [$clog2(MAX_JOBS)-1:0] start_slot,
    output logic                        found,
    output logic [$clog2(MAX_JOBS)-1:0] pick
);

    localparam int IW = $clog2(MAX_JOBS);

    logic          found_hi;
    logic          found_lo;
    logic [IW-1:0] pick_hi;
    logic [IW-1:0] pick_lo;

    // lowest live slot overall and lowest live slot from the start on
    always_comb
    begin
        found_hi = 1'b0;
        found_lo = 1'b0;
        pick_hi  = '0;
        pick_lo  = '0;
        for (int i = MAX_JOBS - 1; i >= 0; i--)
        begin
            if (live[i] && ((IW + 1)'(i) < jobs_used))
            begin
                found_lo = 1'b1;
                pick_lo  = IW'(i);
                if (IW'(i) >= start_slot)
                begin
                    found_hi = 1'b1;
                    pick_hi  = IW'(i);
                end
            end
        end
    end

    assign found = found_lo;
    assign pick  = found_hi ? pick_hi : pick_lo;

endmodule

// ----- design/round_robin_slice_scheduler_core.sv -----
// round_robin_slice_scheduler_core: top level of the round-robin slice scheduler
// depends on rrss_pkg, rrss_job_mem and rrss_picker
`timescale 1ns / 1ps

// Usage
// Input items arrive on the s_ stream: s_tuser is the opcode (load or slice),
// s_tdata carries the slot and the burst. Every item returns exactly one item
// on the m_ stream: m_tuser says whether a slice ran, m_tdata carries the
// Gantt record, the finish times, the running totals and the all-done flag.
// The quantum and the job count are written on the cfg_ port; the user must write them
// only while idle, which the block itself does not enforce. A load goes from acceptance
// to the final step. No new item is taken until the last has left its final step; the slice path is
// a read of the job tables, a run/update step that writes back the remaining
// time, a waiting-time step and the totals step into the output register.
// The next live job is found combinationally from a per-slot live flag.
// A new item is taken while a finished result still waits in the output
// register; if the receiver stalls, the next item holds in its final step.
// Reset clears the clock, pointer, totals, live flags and registers (quantum
// 5, job count 4); the job tables themselves are not cleared.

module round_robin_slice_scheduler_core #(
    parameter int MAX_JOBS  = rrss_pkg::MAX_JOBS_DEF,
    parameter int TIME_BITS = rrss_pkg::TIME_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // s_tdata, low bit up: slot_index[4], burst[16], zero pad[4]
    input  logic [rrss_pkg::IN_DATA_W-1:0]     s_tdata,
    // s_tuser: opcode[1]
    input  logic                               s_tuser,
    // output stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // m_tdata, low bit up: job_index[4], start_time[20], run_length[16],
    // job_finished[1], wait_time[20], turnaround[20], total_wait[25],
    // total_turnaround[25], all_done[1], zero pad[4]
    output logic [rrss_pkg::OUT_DATA_W-1:0]    m_tdata,
    // m_tuser: slice_valid[1]
    output logic                               m_tuser,
    // configuration write port
    input  logic                               cfg_wr_en,
    input  logic [rrss_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [rrss_pkg::QUANTUM_W-1:0]     cfg_data
);

    localparam int IW   = $clog2(MAX_JOBS);
    localparam int NW   = (IW + 1 > rrss_pkg::JOBCNT_W) ? IW + 1 : rrss_pkg::JOBCNT_W;
    localparam int SW   = (IW + 1 > rrss_pkg::SLOT_W) ? IW + 1 : rrss_pkg::SLOT_W;
    localparam int XW   = (IW > rrss_pkg::SLOT_W) ? IW : rrss_pkg::SLOT_W;
    localparam int BX   = (TIME_BITS > rrss_pkg::BURST_W) ? TIME_BITS : rrss_pkg::BURST_W;
    localparam int CMPW = (TIME_BITS > rrss_pkg::RUN_W) ? TIME_BITS : rrss_pkg::RUN_W;
    localparam int WW   = (TIME_BITS > rrss_pkg::CLOCK_W) ? TIME_BITS : rrss_pkg::CLOCK_W;

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    // kind of item in flight
    localparam logic [1:0] K_LOAD  = 2'd0;
    localparam logic [1:0] K_NONE  = 2'd1;
    localparam logic [1:0] K_SLICE = 2'd2;

    // configuration
    logic [rrss_pkg::QUANTUM_W-1:0] quantum_reg;
    logic [rrss_pkg::JOBCNT_W-1:0]  job_count_reg;

    // control and scheduler state
    logic [1:0]                     state_reg, state_next;
    logic [1:0]                     kind_reg, kind_next;
    logic [MAX_JOBS-1:0]            live_reg, live_next;
    logic [IW-1:0]                  ptr_reg, ptr_next;
    logic [rrss_pkg::CLOCK_W-1:0]   clock_reg, clock_next;
    logic [rrss_pkg::SUM_W-1:0]     wsum_reg, wsum_next;
    logic [rrss_pkg::SUM_W-1:0]     tsum_reg, tsum_next;
    logic                           m_tvalid_reg, m_tvalid_next;

    // payload of the item in flight
    logic [IW-1:0]                  pick_reg, pick_next;
    logic [rrss_pkg::CLOCK_W-1:0]   start_reg, start_next;
    logic [rrss_pkg::RUN_W-1:0]     run_reg, run_next;
    logic                           fin_reg, fin_next;
    logic [rrss_pkg::CLOCK_W-1:0]   wait_reg, wait_next;
    logic [rrss_pkg::OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                           m_tuser_reg, m_tuser_next;

    // decoded input and derived values
    logic                           accept;
    logic [rrss_pkg::SLOT_W-1:0]    slot_in;
    logic [rrss_pkg::BURST_W-1:0]   burst_in;
    logic [TIME_BITS-1:0]           burst_m;
    logic                           slot_ok;
    logic [IW-1:0]                  slot_addr;
    logic [NW-1:0]                  n_wide;
    logic [IW:0]                    jobs_used;
    logic [IW-1:0]                  start_slot;
    logic                           found;
    logic [IW-1:0]                  pick;
    logic                           out_free;

    // run step values
    logic [rrss_pkg::QUANTUM_W-1:0] q_eff;
    logic [CMPW-1:0]                run_wide;
    logic [TIME_BITS-1:0]           rem_new;
    logic [rrss_pkg::CLOCK_W:0]     clock_sum;
    logic [IW:0]                    ptr_inc;

    // totals step values
    logic [rrss_pkg::SUM_W:0]       wsum_add;
    logic [rrss_pkg::SUM_W:0]       tsum_add;
    logic [rrss_pkg::SUM_W-1:0]     wsum_fin;
    logic [rrss_pkg::SUM_W-1:0]     tsum_fin;
    logic [rrss_pkg::CLOCK_W-1:0]   wait_o;
    logic [rrss_pkg::CLOCK_W-1:0]   tat_o;
    logic                           slice_o;

    // memory control
    logic                           mem_rd_en;
    logic                           mem_wr_en;
    logic                           mem_burst_wr_en;
    logic [IW-1:0]                  mem_wr_addr;
    logic [TIME_BITS-1:0]           mem_wr_rem;
    logic [TIME_BITS-1:0]           rd_rem;
    logic [TIME_BITS-1:0]           rd_burst;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quantum_reg   <= rrss_pkg::QUANTUM_RST;
            job_count_reg <= rrss_pkg::JOBCNT_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                rrss_pkg::REG_QUANTUM:   quantum_reg   <= cfg_data;
                rrss_pkg::REG_JOB_COUNT: job_count_reg <= cfg_data[rrss_pkg::JOBCNT_W-1:0];
                default:                 quantum_reg   <= quantum_reg;
            endcase
        end
    end

    // input decode
    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign slot_in   = s_tdata[rrss_pkg::SLOT_W-1:0];
    assign burst_in  = s_tdata[rrss_pkg::SLOT_W +: rrss_pkg::BURST_W];
    assign burst_m   = TIME_BITS'(BX'(burst_in));
    assign slot_ok   = (SW'(slot_in) < SW'(MAX_JOBS));
    assign slot_addr = IW'(XW'(slot_in));

    // jobs in use, clamped to one..MAX_JOBS
    always_comb
    begin
        n_wide = NW'(job_count_reg);
        if (job_count_reg == '0)
        begin
            n_wide = NW'(1);
        end
        else if (NW'(job_count_reg) > NW'(MAX_JOBS))
        begin
            n_wide = NW'(MAX_JOBS);
        end
    end
    assign jobs_used  = (IW + 1)'(n_wide);
    assign start_slot = ({1'b0, ptr_reg} < jobs_used) ? ptr_reg : '0;

    // next live job search
    rrss_picker #(
        .MAX_JOBS (MAX_JOBS)
    ) u_picker (
        .live       (live_reg),
        .jobs_used  (jobs_used),
        .start_slot (start_slot),
        .found      (found),
        .pick       (pick)
    );

    // job tables
    rrss_job_mem #(
        .MAX_JOBS  (MAX_JOBS),
        .TIME_BITS (TIME_BITS)
    ) u_job_mem (
        .clk          (clk),
        .rd_en        (mem_rd_en),
        .rd_addr      (pick),
        .wr_en        (mem_wr_en),
        .wr_addr      (mem_wr_addr),
        .wr_remaining (mem_wr_rem),
        .burst_wr_en  (mem_burst_wr_en),
        .wr_burst     (burst_m),
        .rd_remaining (rd_rem),
        .rd_burst     (rd_burst)
    );

    // run step: slice length, new remaining time, clock and pointer
    assign q_eff     = (quantum_reg == '0) ? rrss_pkg::QUANTUM_W'(1) : quantum_reg;
    assign run_wide  = (CMPW'(rd_rem) <= CMPW'(q_eff)) ? CMPW'(rd_rem) : CMPW'(q_eff);
    assign rem_new   = rd_rem - TIME_BITS'(run_wide);
    assign clock_sum = {1'b0, clock_reg} + (rrss_pkg::CLOCK_W + 1)'(run_wide);
    assign ptr_inc   = {1'b0, pick_reg} + (IW + 1)'(1);

    // memory control: both tables written on a load, remaining time on a run step, read on a slice
    always_comb
    begin
        mem_rd_en       = 1'b0;
        mem_wr_en       = 1'b0;
        mem_burst_wr_en = 1'b0;
        mem_wr_addr     = pick_reg;
        mem_wr_rem      = rem_new;
        if (state_reg == S_IDLE && accept)
        begin
            if (s_tuser == rrss_pkg::OP_LOAD)
            begin
                mem_wr_en       = slot_ok;
                mem_burst_wr_en = slot_ok;
                mem_wr_addr     = slot_addr;
                mem_wr_rem      = burst_m;
            end
            else
            begin
                mem_rd_en = found;
            end
        end
        else if (state_reg == S_EXEC)
        begin
            mem_wr_en = 1'b1;
        end
    end

    // totals step: saturating sums and record fields
    assign slice_o  = (kind_reg == K_SLICE);
    assign wsum_add = {1'b0, wsum_reg} + (rrss_pkg::SUM_W + 1)'(wait_reg);
    assign tsum_add = {1'b0, tsum_reg} + (rrss_pkg::SUM_W + 1)'(clock_reg);
    assign wsum_fin = (slice_o && fin_reg)
                      ? ((wsum_add > (rrss_pkg::SUM_W + 1)'(rrss_pkg::SUM_MAX))
                         ? rrss_pkg::SUM_MAX : rrss_pkg::SUM_W'(wsum_add))
                      : wsum_reg;
    assign tsum_fin = (slice_o && fin_reg)
                      ? ((tsum_add > (rrss_pkg::SUM_W + 1)'(rrss_pkg::SUM_MAX))
                         ? rrss_pkg::SUM_MAX : rrss_pkg::SUM_W'(tsum_add))
                      : tsum_reg;
    assign wait_o   = (slice_o && fin_reg) ? wait_reg : '0;
    assign tat_o    = (slice_o && fin_reg) ? clock_reg : '0;
    assign out_free = !m_tvalid_reg || m_tready;

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        kind_next     = kind_reg;
        live_next     = live_reg;
        ptr_next      = ptr_reg;
        clock_next    = clock_reg;
        wsum_next     = wsum_reg;
        tsum_next     = tsum_reg;
        pick_next     = pick_reg;
        start_next    = start_reg;
        run_next      = run_reg;
        fin_next      = fin_reg;
        wait_next     = wait_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser == rrss_pkg::OP_LOAD)
                    begin
                        // load: store burst, restart the schedule
                        if (slot_ok)
                        begin
                            live_next[slot_addr] = (burst_m != '0);
                        end
                        ptr_next   = '0;
                        clock_next = '0;
                        wsum_next  = '0;
                        tsum_next  = '0;
                        kind_next  = K_LOAD;
                        state_next = S_FIN;
                    end
                    else if (found)
                    begin
                        pick_next  = pick;
                        kind_next  = K_SLICE;
                        state_next = S_EXEC;
                    end
                    else
                    begin
                        kind_next  = K_NONE;
                        state_next = S_FIN;
                    end
                end
            end
            S_EXEC:
            begin
                // run the picked job for one slice
                run_next            = rrss_pkg::RUN_W'(run_wide);
                start_next          = clock_reg;
                fin_next            = (rem_new == '0);
                live_next[pick_reg] = (rem_new != '0);
                clock_next          = (clock_sum > (rrss_pkg::CLOCK_W + 1)'(rrss_pkg::CLOCK_MAX))
                                      ? rrss_pkg::CLOCK_MAX
                                      : rrss_pkg::CLOCK_W'(clock_sum);
                ptr_next            = (ptr_inc == jobs_used) ? '0 : IW'(ptr_inc);
                state_next          = S_WAIT;
            end
            S_WAIT:
            begin
                // waiting time, floored at zero
                wait_next  = (WW'(clock_reg) >= WW'(rd_burst))
                             ? rrss_pkg::CLOCK_W'(WW'(clock_reg) - WW'(rd_burst))
                             : '0;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    wsum_next     = wsum_fin;
                    tsum_next     = tsum_fin;
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = slice_o;
                    m_tdata_next  = {4'b0,
                                     !found,
                                     tsum_fin,
                                     wsum_fin,
                                     tat_o,
                                     wait_o,
                                     slice_o && fin_reg,
                                     slice_o ? run_reg : '0,
                                     slice_o ? start_reg : '0,
                                     slice_o ? rrss_pkg::SLOT_W'(XW'(pick_reg)) : '0};
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            kind_reg     <= K_LOAD;
            live_reg     <= '0;
            ptr_reg      <= '0;
            clock_reg    <= '0;
            wsum_reg     <= '0;
            tsum_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            kind_reg     <= kind_next;
            live_reg     <= live_next;
            ptr_reg      <= ptr_next;
            clock_reg    <= clock_next;
            wsum_reg     <= wsum_next;
            tsum_reg     <= tsum_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pick_reg    <= pick_next;
        start_reg   <= start_next;
        run_reg     <= run_next;
        fin_reg     <= fin_next;
        wait_reg    <= wait_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTHESIS
    // a picked job always has time left in the table
    a_pick_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC) |-> (rd_rem != '0))
        else $error("picked job has no remaining time");

    // a run step never moves the clock backward
    a_clock_mono: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC) |=> (clock_reg >= $past(clock_reg)))
        else $error("clock moved backward on a slice");

    // the pointer stays inside the slots in use after a run step
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WAIT) |-> ({1'b0, ptr_reg} < jobs_used))
        else $error("pointer outside the slots in use");

    // a delivered result returns the sequencer to idle with the output loaded
    a_fin_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && out_free) |=> (state_reg == S_IDLE && m_tvalid_reg))
        else $error("final step did not hand over its result");
`endif

endmodule

// ----- verif/tb_round_robin_slice_scheduler_core.sv -----
// tb_round_robin_slice_scheduler_core: self-checking bench for the round-robin slice scheduler
// drives load and slice items with random idling and checks every Gantt record
// against its own scheduler model or directed values; depends on rrss_pkg and round_robin_slice_scheduler_core
`timescale 1ns / 1ps

module tb_round_robin_slice_scheduler_core;

    import rrss_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 300;
    localparam int RANDOM_ITEMS   = 450;
    localparam int SETTLE_CYCLES  = 8;
    localparam int NUM_SLOTS      = MAX_JOBS_DEF;

    // one Gantt record as seen on the output stream
    typedef struct {
        logic                 slice_valid;
        logic [SLOT_W-1:0]    job_index;
        logic [CLOCK_W-1:0]   start_time;
        logic [RUN_W-1:0]     run_length;
        logic                 job_finished;
        logic [CLOCK_W-1:0]   wait_time;
        logic [CLOCK_W-1:0]   turnaround;
        logic [SUM_W-1:0]     total_wait;
        logic [SUM_W-1:0]     total_turnaround;
        logic                 all_done;
    } gantt_rec_t;

    // one row of the directed table: a register write or an item
    typedef struct {
        bit                       is_cfg;
        logic [CFG_INDEX_W-1:0]   reg_idx;
        logic [QUANTUM_W-1:0]     reg_val;
        logic                     op;
        logic [SLOT_W-1:0]        slot;
        logic [BURST_W-1:0]       burst;
        bit                       typed;
        gantt_rec_t               want;
    } stim_row_t;

    logic                       clk;
    logic                       rst_n     = 1'b0;
    logic                       s_tvalid  = 1'b0;
    logic                       s_tready;
    logic [IN_DATA_W-1:0]       s_tdata   = '0;
    logic                       s_tuser   = 1'b0;
    logic                       m_tvalid;
    logic                       m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0]      m_tdata;
    logic                       m_tuser;
    logic                       cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0]     cfg_index = '0;
    logic [QUANTUM_W-1:0]       cfg_data  = '0;

    // scheduler model state
    logic [BURST_W-1:0]         left_time [NUM_SLOTS];
    logic [BURST_W-1:0]         job_burst [NUM_SLOTS];
    logic [CLOCK_W-1:0]         sim_clock     = '0;
    int unsigned                rr_ptr        = 0;
    logic [SUM_W-1:0]           wait_total    = '0;
    logic [SUM_W-1:0]           tat_total     = '0;
    logic [QUANTUM_W-1:0]       cur_quantum   = QUANTUM_RST;
    logic [JOBCNT_W-1:0]        cur_job_count = JOBCNT_RST;

    gantt_rec_t                 pending_records [$];
    int unsigned                mismatches    = 0;
    int unsigned                send_idle_pct = 0;
    int unsigned                recv_idle_pct = 0;
    bit                         hold_req      = 1'b0;

    round_robin_slice_scheduler_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 100 MHz clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // job count clamped to 1..NUM_SLOTS
    function automatic int unsigned slots_in_use();
        int unsigned n;
        n = cur_job_count;
        if (n == 0)
            n = 1;
        if (n > NUM_SLOTS)
            n = NUM_SLOTS;
        return n;
    endfunction

    function automatic bit no_work_left(int unsigned n);
        for (int i = 0; i < n; i++)
            if (left_time[i] != 0)
                return 1'b0;
        return 1'b1;
    endfunction

    // model of one item: updates the scheduler state and returns its record
    function automatic gantt_rec_t schedule_step(logic op, logic [SLOT_W-1:0] slot,
                                                 logic [BURST_W-1:0] burst);
        gantt_rec_t  rec;
        int unsigned n;
        int unsigned q;
        int unsigned first;
        int unsigned idx;
        int unsigned run;
        int unsigned tat;
        int unsigned w;
        int          pick;
        rec = '{default: '0};
        n = slots_in_use();
        q = (cur_quantum == 0) ? 1 : cur_quantum;
        pick = -1;
        // load: store the burst and restart the schedule
        if (op == OP_LOAD)
        begin
            job_burst[slot] = burst;
            left_time[slot] = burst;
            sim_clock = '0;
            rr_ptr = 0;
            wait_total = '0;
            tat_total = '0;
            rec.all_done = no_work_left(n);
            return rec;
        end
        // search from the pointer for a job with time left
        first = (rr_ptr < n) ? rr_ptr : 0;
        for (int k = 0; k < n && pick < 0; k++)
        begin
            idx = (first + k) % n;
            if (left_time[idx] != 0)
                pick = idx;
        end
        if (pick < 0)
        begin
            rec.total_wait = wait_total;
            rec.total_turnaround = tat_total;
            rec.all_done = 1'b1;
            return rec;
        end
        // run the slice
        run = (left_time[pick] <= q) ? left_time[pick] : q;
        rec.slice_valid = 1'b1;
        rec.job_index = pick[SLOT_W-1:0];
        rec.start_time = sim_clock;
        rec.run_length = run[RUN_W-1:0];
        sim_clock = (sim_clock + run > CLOCK_MAX) ? CLOCK_MAX : sim_clock + run;
        left_time[pick] = left_time[pick] - run[BURST_W-1:0];
        rr_ptr = (pick + 1) % n;
        // completion: waiting and turnaround times, saturating totals
        if (left_time[pick] == 0)
        begin
            tat = sim_clock;
            w = (tat >= job_burst[pick]) ? tat - job_burst[pick] : 0;
            wait_total = (wait_total + w > SUM_MAX) ? SUM_MAX : wait_total + w;
            tat_total = (tat_total + tat > SUM_MAX) ? SUM_MAX : tat_total + tat;
            rec.job_finished = 1'b1;
            rec.wait_time = w[CLOCK_W-1:0];
            rec.turnaround = tat[CLOCK_W-1:0];
        end
        rec.total_wait = wait_total;
        rec.total_turnaround = tat_total;
        rec.all_done = no_work_left(n);
        return rec;
    endfunction

    // directed table rows
    function automatic stim_row_t reg_row(logic [CFG_INDEX_W-1:0] idx, logic [QUANTUM_W-1:0] val);
        stim_row_t row;
        row = '{default: '0};
        row.want = '{default: '0};
        row.is_cfg = 1'b1;
        row.reg_idx = idx;
        row.reg_val = val;
        return row;
    endfunction

    function automatic stim_row_t item_row(logic op, logic [SLOT_W-1:0] slot,
                                           logic [BURST_W-1:0] burst);
        stim_row_t row;
        row = '{default: '0};
        row.want = '{default: '0};
        row.op = op;
        row.slot = slot;
        row.burst = burst;
        return row;
    endfunction

    // load whose record is all zero except all_done
    function automatic stim_row_t load_row(logic [SLOT_W-1:0] slot, logic [BURST_W-1:0] burst,
                                           logic done);
        stim_row_t row;
        row = item_row(OP_LOAD, slot, burst);
        row.typed = 1'b1;
        row.want.all_done = done;
        return row;
    endfunction

    function automatic stim_row_t slice_row(logic valid, int unsigned job, int unsigned start,
                                            int unsigned run, logic fin, int unsigned w,
                                            int unsigned tat, int unsigned tw, int unsigned tt,
                                            logic done);
        stim_row_t row;
        row = item_row(OP_SLICE, '0, '0);
        row.typed = 1'b1;
        row.want.slice_valid = valid;
        row.want.job_index = job;
        row.want.start_time = start;
        row.want.run_length = run;
        row.want.job_finished = fin;
        row.want.wait_time = w;
        row.want.turnaround = tat;
        row.want.total_wait = tw;
        row.want.total_turnaround = tt;
        row.want.all_done = done;
        return row;
    endfunction

    // burst mix: mostly short jobs, some zero and some full-range
    function automatic logic [BURST_W-1:0] pick_burst();
        int unsigned r;
        r = $urandom_range(15);
        if (r == 0)
            return '0;
        if (r == 1)
            return $urandom;
        return $urandom_range(1, 12);
    endfunction

    // offer one item, wait for acceptance and queue its expected record
    task automatic send_item(logic op, logic [SLOT_W-1:0] slot, logic [BURST_W-1:0] burst,
                             bit typed, gantt_rec_t want);
        gantt_rec_t predicted;
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(IN_DATA_W - SLOT_W - BURST_W){1'b0}}, burst, slot};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted = schedule_step(op, slot, burst);
        if (typed)
            pending_records.push_back(want);
        else
            pending_records.push_back(predicted);
    endtask

    // drain all results so that registers can be written safely
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_records.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [QUANTUM_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        if (idx == REG_QUANTUM)
            cur_quantum = val;
        else
            cur_job_count = val[JOBCNT_W-1:0];
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // result side: check each record, then pick m_tready for the next cycle
    initial
    begin
        gantt_rec_t got;
        gantt_rec_t want;
        int unsigned hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                got.slice_valid      = m_tuser;
                got.job_index        = m_tdata[3:0];
                got.start_time       = m_tdata[23:4];
                got.run_length       = m_tdata[39:24];
                got.job_finished     = m_tdata[40];
                got.wait_time        = m_tdata[60:41];
                got.turnaround       = m_tdata[80:61];
                got.total_wait       = m_tdata[105:81];
                got.total_turnaround = m_tdata[130:106];
                got.all_done         = m_tdata[131];
                if (pending_records.size() == 0)
                begin
                    $error("result item arrived with nothing expected");
                    mismatches++;
                end
                else
                begin
                    want = pending_records.pop_front();
                    check_field("slice_valid", want.slice_valid, got.slice_valid);
                    check_field("job_index", want.job_index, got.job_index);
                    check_field("start_time", want.start_time, got.start_time);
                    check_field("run_length", want.run_length, got.run_length);
                    check_field("job_finished", want.job_finished, got.job_finished);
                    check_field("wait_time", want.wait_time, got.wait_time);
                    check_field("turnaround", want.turnaround, got.turnaround);
                    check_field("total_wait", want.total_wait, got.total_wait);
                    check_field("total_turnaround", want.total_turnaround,
                                got.total_turnaround);
                    check_field("all_done", want.all_done, got.all_done);
                end
            end
            // long hold-off once, otherwise random stalls
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog on cycles without any accepted item
    initial
    begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL");
        $finish;
    end

    // stimulus
    initial
    begin
        stim_row_t   directed_rows [$];
        gantt_rec_t  no_rec;
        int unsigned random_items;
        int unsigned n;
        int unsigned r;
        int unsigned loads;
        int unsigned slices;
        logic [QUANTUM_W-1:0] q_val;
        logic [QUANTUM_W-1:0] jc_val;
        bit          hold_done;

        no_rec = '{default: '0};
        hold_done = 1'b0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            left_time[i] = '0;
            job_burst[i] = '0;
        end

        // one slot in use first, so no unloaded slot is ever looked at
        directed_rows = '{
            reg_row(REG_JOB_COUNT, 16'd1),
            load_row(4'd0, 16'd0, 1'b1),
            slice_row(1'b0, 0, 0, 0, 1'b0, 0, 0, 0, 0, 1'b1),
            load_row(4'd1, 16'hFFFF, 1'b1),
            load_row(4'd2, 16'h8000, 1'b1),
            load_row(4'd3, 16'h5555, 1'b1),
            load_row(4'd4, 16'hAAAA, 1'b1),
            load_row(4'd5, 16'd1, 1'b1),
            load_row(4'd6, 16'd7, 1'b1),
            load_row(4'd7, 16'd3, 1'b1),
            load_row(4'd8, 16'd20, 1'b1),
            load_row(4'd9, 16'h00FF, 1'b1),
            load_row(4'd10, 16'hFF00, 1'b1),
            load_row(4'd11, 16'd9, 1'b1),
            load_row(4'd12, 16'd2, 1'b1),
            load_row(4'd13, 16'h0F0F, 1'b1),
            load_row(4'd14, 16'hF0F0, 1'b1),
            load_row(4'd15, 16'd30, 1'b1),
            load_row(4'd0, 16'd12, 1'b0),
            // reset quantum of 5: two full slices, then the job completes
            slice_row(1'b1, 0, 0, 5, 1'b0, 0, 0, 0, 0, 1'b0),
            slice_row(1'b1, 0, 5, 5, 1'b0, 0, 0, 0, 0, 1'b0),
            slice_row(1'b1, 0, 10, 2, 1'b1, 0, 12, 0, 12, 1'b1),
            slice_row(1'b0, 0, 0, 0, 1'b0, 0, 0, 0, 12, 1'b1),
            // all slots, largest quantum
            reg_row(REG_JOB_COUNT, 16'd16),
            reg_row(REG_QUANTUM, 16'hFFFF),
            item_row(OP_SLICE, 4'd15, 16'hFFFF),
            item_row(OP_SLICE, 4'd0, 16'd0),
            item_row(OP_SLICE, 4'd7, 16'h1234),
            // zero quantum runs as one, job count above the table clamps
            reg_row(REG_QUANTUM, 16'd0),
            reg_row(REG_JOB_COUNT, 16'd31),
            item_row(OP_SLICE, 4'd3, 16'd0),
            // zero job count acts as a single slot
            reg_row(REG_JOB_COUNT, 16'd0),
            item_row(OP_LOAD, 4'd0, 16'd3),
            item_row(OP_SLICE, 4'd9, 16'hFFFF)
        };

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 29;
        recv_idle_pct = 85;
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_cfg)
            begin
                settle();
                write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
            end
            else
                send_item(directed_rows[i].op, directed_rows[i].slot, directed_rows[i].burst,
                          directed_rows[i].typed, directed_rows[i].want);
        end

        // random episodes: new settings, loads in most, then a run of mostly slices
        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            settle();
            if (random_items < RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 29;
                recv_idle_pct = 85;
            end
            else if (random_items < 2 * RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 85;
                recv_idle_pct = 29;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            r = $urandom_range(9);
            if (r == 0)
                q_val = '0;
            else if (r == 1)
                q_val = 16'hFFFF;
            else if (r == 2)
                q_val = $urandom;
            else
                q_val = $urandom_range(1, 12);
            r = $urandom_range(7);
            if (r == 0)
                jc_val = 16'd0;
            else if (r == 1)
                jc_val = 16'd16;
            else if (r == 2)
                jc_val = $urandom_range(17, 31);
            else
                jc_val = $urandom_range(1, 8);
            write_reg(REG_QUANTUM, q_val);
            write_reg(REG_JOB_COUNT, jc_val);

            // back pressure: receiver holds off while items keep coming
            if (send_idle_pct == 0 && !hold_done)
            begin
                hold_req = 1'b1;
                hold_done = 1'b1;
            end

            // some episodes keep the old jobs, leaving the pointer stale
            n = slots_in_use();
            if ($urandom_range(3) != 0)
            begin
                loads = $urandom_range(1, n);
                repeat (loads)
                begin
                    send_item(OP_LOAD, $urandom_range(n - 1), pick_burst(), 1'b0, no_rec);
                    random_items++;
                end
            end
            slices = $urandom_range(4, 40);
            repeat (slices)
            begin
                if ($urandom_range(11) == 0)
                    send_item(OP_LOAD, $urandom_range(15), pick_burst(), 1'b0, no_rec);
                else
                    send_item(OP_SLICE, $urandom_range(15), $urandom, 1'b0, no_rec);
                random_items++;
            end
        end

        // drain and report
        s_tvalid <= 1'b0;
        while (pending_records.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
